// ===== sv/fmef_pkg.sv =====
// ============================================================================
// fmef_pkg
// Shared types and codes for the flight-mode supervisor: modes, event codes,
// commands, status and action codes, and the structs passed between modules.
// ============================================================================
package fmef_pkg;

    typedef logic [2:0] mode_t;
    typedef logic [4:0] code_t;
    typedef logic [1:0] action_t;
    typedef logic [1:0] status_t;
    typedef logic [4:0] qcount_t;

    // Flight modes.
    localparam mode_t MODE_OFF     = 3'd0;
    localparam mode_t MODE_INIT    = 3'd1;
    localparam mode_t MODE_TAKEOFF = 3'd2;
    localparam mode_t MODE_HOVER   = 3'd3;
    localparam mode_t MODE_MOVE    = 3'd4;
    localparam mode_t MODE_RETURN  = 3'd5;
    localparam mode_t MODE_LAND    = 3'd6;
    localparam mode_t MODE_KILL    = 3'd7;

    // Event codes.
    localparam code_t EV_CTRL_READY      = 5'd0;
    localparam code_t EV_TAKEOFF_REQ     = 5'd1;
    localparam code_t EV_TAKEOFF_DONE    = 5'd2;
    localparam code_t EV_POINT_REQ       = 5'd3;
    localparam code_t EV_WGS84_POINT_REQ = 5'd6;
    localparam code_t EV_HOVER_REQ       = 5'd7;
    localparam code_t EV_WGS84_DONE      = 5'd11;
    localparam code_t EV_RETURN_REQ      = 5'd12;
    localparam code_t EV_LAND_REQ        = 5'd13;
    localparam code_t EV_RETURN_DONE     = 5'd14;
    localparam code_t EV_LAND_DONE       = 5'd15;
    localparam code_t EV_KILL            = 5'd16;

    // Commands.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_PROCESS = 1'b1;

    // Side actions.
    localparam action_t ACT_NONE        = 2'd0;
    localparam action_t ACT_RECORD_HOME = 2'd1;
    localparam action_t ACT_SET_HOVER   = 2'd2;

    // Result status.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_DUPLICATE = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

    // Request from the decision logic to the event queue.
    typedef struct packed {
        logic  push;
        logic  pop;
        code_t code;
    } queue_req_t;

    // Queue state seen by the decision logic.
    typedef struct packed {
        code_t   head_code;
        code_t   newest_code;
        logic    nonempty;
        logic    full;
        qcount_t count_low;
    } queue_stat_t;

    // Outcome of the transition table.
    typedef struct packed {
        logic    hit;
        mode_t   next_mode;
        action_t action;
    } table_res_t;

endpackage

// ===== sv/fmef_queue.sv =====
// ============================================================================
// fmef_queue
// Bounded event FIFO. The oldest entry is kept in a registered read port that
// is refreshed every cycle from the next read pointer, with a bypass for a
// write landing at that address. The newest entry is tracked in a register.
// ============================================================================
module fmef_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fmef_pkg::queue_req_t req,
    output fmef_pkg::queue_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    fmef_pkg::code_t mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] rd_idx_reg;
    logic [PTR_W-1:0] rd_idx_next;
    logic [PTR_W-1:0] wr_idx_reg;
    logic [PTR_W-1:0] wr_idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    fmef_pkg::code_t  head_reg;
    fmef_pkg::code_t  newest_reg;

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        if (req.pop)
        begin
            rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        if (req.push)
        begin
            wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
        end
    end

    // Storage and registered read port; entries hold no reset value.
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[wr_idx_reg] <= req.code;
            newest_reg      <= req.code;
        end
        if (req.push && (wr_idx_reg == rd_idx_next))
            head_reg <= req.code;
        else
            head_reg <= mem[rd_idx_next];
    end

    always_comb
    begin
        stat.head_code   = head_reg;
        stat.newest_code = newest_reg;
        stat.nonempty    = (count_reg != '0);
        stat.full        = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.count_low   = 5'(count_reg);
    end

endmodule

// ===== sv/fmef_mode_table.sv =====
// ============================================================================
// fmef_mode_table
// Mode transition table with its guards. The kill event forces the kill mode
// from every mode; kill mode accepts nothing else.
// ============================================================================
module fmef_mode_table (
    input  fmef_pkg::mode_t     cur_mode,
    input  fmef_pkg::code_t     ev,
    input  logic                ctrl_ok,
    input  logic                takeoff_ok,
    output fmef_pkg::table_res_t res
);

    logic is_move_req;
    logic is_move_done;

    assign is_move_req  = (ev >= fmef_pkg::EV_POINT_REQ) &&
                          (ev <= fmef_pkg::EV_WGS84_POINT_REQ);
    assign is_move_done = (ev >= fmef_pkg::EV_HOVER_REQ) &&
                          (ev <= fmef_pkg::EV_WGS84_DONE);

    always_comb
    begin
        res.hit       = 1'b0;
        res.next_mode = cur_mode;
        res.action    = fmef_pkg::ACT_NONE;
        if (ev == fmef_pkg::EV_KILL)
        begin
            res.hit       = 1'b1;
            res.next_mode = fmef_pkg::MODE_KILL;
        end
        else
        begin
            case (cur_mode)
                fmef_pkg::MODE_OFF:
                begin
                    if (ev == fmef_pkg::EV_CTRL_READY && ctrl_ok)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_INIT;
                    end
                end
                fmef_pkg::MODE_INIT:
                begin
                    if (ev == fmef_pkg::EV_TAKEOFF_REQ && takeoff_ok)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_TAKEOFF;
                        res.action    = fmef_pkg::ACT_RECORD_HOME;
                    end
                end
                fmef_pkg::MODE_TAKEOFF:
                begin
                    if (ev == fmef_pkg::EV_TAKEOFF_DONE)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_HOVER;
                    end
                end
                fmef_pkg::MODE_HOVER, fmef_pkg::MODE_MOVE:
                begin
                    if (is_move_req)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_MOVE;
                    end
                    else if (is_move_done && cur_mode == fmef_pkg::MODE_MOVE)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_HOVER;
                        res.action    = fmef_pkg::ACT_SET_HOVER;
                    end
                    else if (ev == fmef_pkg::EV_RETURN_REQ)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_RETURN;
                    end
                    else if (ev == fmef_pkg::EV_LAND_REQ)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_LAND;
                    end
                end
                fmef_pkg::MODE_RETURN:
                begin
                    if (ev == fmef_pkg::EV_LAND_REQ)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_LAND;
                    end
                    else if (ev == fmef_pkg::EV_HOVER_REQ ||
                             ev == fmef_pkg::EV_RETURN_DONE)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_HOVER;
                        res.action    = fmef_pkg::ACT_SET_HOVER;
                    end
                end
                fmef_pkg::MODE_LAND:
                begin
                    if (ev == fmef_pkg::EV_LAND_DONE)
                    begin
                        res.hit       = 1'b1;
                        res.next_mode = fmef_pkg::MODE_INIT;
                    end
                end
                default:
                begin
                    res.hit = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== sv/flight_mode_event_fsm.sv =====
// ============================================================================
// flight_mode_event_fsm
// Flight-mode supervisor with a bounded event queue. Enqueue transfers push
// an event code, process transfers pop the oldest code and run it through
// the mode transition table. Every input transfer yields one result.
// ============================================================================
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------
//   command   cmd_valid / cmd_ready  command, event_code, ctrl_ready,
//                                    allow_takeoff
//   result    res_valid / res_ready  mode, transitioned, action, status,
//                                    queue_count
//
// One item per cycle is sustained while res_ready stays high: a command is
// held in the input register and decided there, and its result is loaded
// into the output register when the result register is free or draining.
// The decision path is one table lookup plus the queue pointer update.
// A stalled result register holds the input register, which in turn drops
// cmd_ready; both stages move again in the cycle that res_ready returns.
// Reset empties the queue and puts the mode at off; no clearing pass runs.
//
module flight_mode_event_fsm #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic       command,
    input  logic [4:0] event_code,
    input  logic       ctrl_ready,
    input  logic       allow_takeoff,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [2:0] mode,
    output logic       transitioned,
    output logic [1:0] action,
    output logic [1:0] status,
    output logic [4:0] queue_count
);

    // Input register.
    logic            in_valid_reg;
    logic            in_command_reg;
    fmef_pkg::code_t in_code_reg;
    logic            in_ctrl_reg;
    logic            in_takeoff_reg;

    // Result register and the current mode.
    logic              out_valid_reg;
    fmef_pkg::mode_t   out_mode_reg;
    logic              out_trans_reg;
    fmef_pkg::action_t out_action_reg;
    fmef_pkg::status_t out_status_reg;
    fmef_pkg::qcount_t out_count_reg;
    fmef_pkg::mode_t   mode_reg;
    fmef_pkg::mode_t   mode_next;

    fmef_pkg::queue_req_t  q_req;
    fmef_pkg::queue_stat_t q_stat;
    fmef_pkg::table_res_t  tbl;

    logic              advance;
    logic              is_push;
    logic              dup;
    logic              push_ok;
    logic              pop_ok;
    logic              take;
    fmef_pkg::status_t status_now;
    fmef_pkg::qcount_t count_after;

    // The input stage moves into the result register whenever the result
    // register is empty or is being drained in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;

    fmef_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (q_req),
        .stat (q_stat)
    );

    fmef_mode_table u_table (
        .cur_mode  (mode_reg),
        .ev        (q_stat.head_code),
        .ctrl_ok   (in_ctrl_reg),
        .takeoff_ok(in_takeoff_reg),
        .res       (tbl)
    );

    // Decision for the command held in the input register. The duplicate
    // test looks only at the newest entry and wins over the full test.
    always_comb
    begin
        is_push = (in_command_reg == fmef_pkg::CMD_ENQUEUE);
        dup     = q_stat.nonempty && (q_stat.newest_code == in_code_reg);
        push_ok = is_push && !dup && !q_stat.full;
        pop_ok  = !is_push && q_stat.nonempty;
        take    = pop_ok && tbl.hit;

        if (is_push)
        begin
            if (dup)
                status_now = fmef_pkg::ST_DUPLICATE;
            else if (q_stat.full)
                status_now = fmef_pkg::ST_FULL;
            else
                status_now = fmef_pkg::ST_OK;
        end
        else if (!q_stat.nonempty)
            status_now = fmef_pkg::ST_EMPTY;
        else
            status_now = fmef_pkg::ST_OK;

        // The reported count is the low five bits, so wrapping adds are exact.
        if (push_ok)
            count_after = q_stat.count_low + 5'd1;
        else if (pop_ok)
            count_after = q_stat.count_low - 5'd1;
        else
            count_after = q_stat.count_low;

        q_req.push = advance && push_ok;
        q_req.pop  = advance && pop_ok;
        q_req.code = in_code_reg;

        mode_next = (advance && take) ? tbl.next_mode : mode_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= fmef_pkg::MODE_OFF;
        end
        else
        begin
            if (cmd_ready)
                in_valid_reg <= cmd_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
            mode_reg <= mode_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            in_command_reg <= command;
            in_code_reg    <= event_code;
            in_ctrl_reg    <= ctrl_ready;
            in_takeoff_reg <= allow_takeoff;
        end
        if (advance)
        begin
            out_mode_reg   <= mode_next;
            out_trans_reg  <= take;
            out_action_reg <= take ? tbl.action : fmef_pkg::ACT_NONE;
            out_status_reg <= status_now;
            out_count_reg  <= count_after;
        end
    end

    assign res_valid    = out_valid_reg;
    assign mode         = out_mode_reg;
    assign transitioned = out_trans_reg;
    assign action       = out_action_reg;
    assign status       = out_status_reg;
    assign queue_count  = out_count_reg;

endmodule

// ===== sv/fmef_checker.sv =====
// ============================================================================
// fmef_checker
// Port-level checks on the supervisor's results, bound to the top level.
// ============================================================================
module fmef_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] mode,
    input logic       transitioned,
    input logic [1:0] action,
    input logic [1:0] status,
    input logic [4:0] queue_count
);

    // An action only fires together with an accepted transition.
    a_action_needs_trans: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !transitioned |-> action == fmef_pkg::ACT_NONE)
        else $error("action without transition");

    // Only a popped event can move the mode.
    a_trans_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && transitioned |-> status == fmef_pkg::ST_OK)
        else $error("transition with non-ok status");

    // A pop that found the queue empty leaves it empty.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == fmef_pkg::ST_EMPTY |-> queue_count == 5'd0)
        else $error("empty status with nonzero count");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mode) &&
        $stable(status) && $stable(queue_count))
        else $error("stalled result changed");

    // With no result waiting, a command is always taken.
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("command refused with empty result register");

endmodule

bind flight_mode_event_fsm fmef_checker u_fmef_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_ready   (cmd_ready),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .mode        (mode),
    .transitioned(transitioned),
    .action      (action),
    .status      (status),
    .queue_count (queue_count)
);

// ===== bench/flight_mode_event_fsm_tb.sv =====
// ============================================================================
// flight_mode_event_fsm_tb
// Self-checking bench for the flight-mode supervisor. A local prediction of
// the mode table and the event queue runs in step with every accepted command
// transfer, and every result transfer is compared field by field with the
// oldest prediction. Both channels idle and stall at random.
// ============================================================================
`timescale 1ns / 1ps

module flight_mode_event_fsm_tb;

    localparam int QDEPTH = 16;

    // One result transfer as the block presents it.
    typedef struct {
        fmef_pkg::mode_t   mode;
        logic              transitioned;
        fmef_pkg::action_t action;
        fmef_pkg::status_t status;
        fmef_pkg::qcount_t qcount;
    } flight_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    logic       command;
    logic [4:0] event_code;
    logic       ctrl_ready;
    logic       allow_takeoff;
    logic       res_valid;
    logic       res_ready;
    logic [2:0] mode;
    logic       transitioned;
    logic [1:0] action;
    logic [1:0] status;
    logic [4:0] queue_count;

    // Predicted supervisor state: the current mode and the event queue.
    fmef_pkg::mode_t sup_mode;
    fmef_pkg::code_t event_fifo [QDEPTH];
    int              fifo_rd;
    int              fifo_wr;
    int              fifo_count;

    // Results predicted for accepted commands, oldest first.
    flight_result_t pending_results [$];

    // When set, neither side inserts idle cycles.
    logic quiet = 1'b0;

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int status_hits [4];
    int action_hits [3];
    logic [7:0] modes_seen = '0;

    flight_mode_event_fsm #(
        .QUEUE_DEPTH (QDEPTH)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .command          (command),
        .event_code       (event_code),
        .ctrl_ready       (ctrl_ready),
        .allow_takeoff    (allow_takeoff),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .mode             (mode),
        .transitioned     (transitioned),
        .action           (action),
        .status           (status),
        .queue_count      (queue_count)
    );

    // 8 ns clock period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // The fixed transition table, guards included. A miss leaves the mode.
    function automatic fmef_pkg::table_res_t mode_table(fmef_pkg::mode_t m,
                                                        fmef_pkg::code_t ev,
                                                        logic rdy, logic tko);
        fmef_pkg::table_res_t r;
        r.hit       = 1'b0;
        r.next_mode = m;
        r.action    = fmef_pkg::ACT_NONE;
        case (m)
            fmef_pkg::MODE_OFF:
                if (ev == fmef_pkg::EV_CTRL_READY && rdy)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_INIT;
                end
            fmef_pkg::MODE_INIT:
                if (ev == fmef_pkg::EV_TAKEOFF_REQ && tko)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_TAKEOFF;
                    r.action = fmef_pkg::ACT_RECORD_HOME;
                end
            fmef_pkg::MODE_TAKEOFF:
                if (ev == fmef_pkg::EV_TAKEOFF_DONE)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_HOVER;
                end
            fmef_pkg::MODE_HOVER:
                if (ev >= fmef_pkg::EV_POINT_REQ && ev <= fmef_pkg::EV_WGS84_POINT_REQ)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_MOVE;
                end
                else if (ev == fmef_pkg::EV_RETURN_REQ)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_RETURN;
                end
                else if (ev == fmef_pkg::EV_LAND_REQ)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_LAND;
                end
            fmef_pkg::MODE_MOVE:
                if (ev >= fmef_pkg::EV_POINT_REQ && ev <= fmef_pkg::EV_WGS84_POINT_REQ)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_MOVE;
                end
                else if (ev >= fmef_pkg::EV_HOVER_REQ && ev <= fmef_pkg::EV_WGS84_DONE)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_HOVER;
                    r.action = fmef_pkg::ACT_SET_HOVER;
                end
                else if (ev == fmef_pkg::EV_RETURN_REQ)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_RETURN;
                end
                else if (ev == fmef_pkg::EV_LAND_REQ)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_LAND;
                end
            fmef_pkg::MODE_RETURN:
                if (ev == fmef_pkg::EV_LAND_REQ)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_LAND;
                end
                else if (ev == fmef_pkg::EV_HOVER_REQ || ev == fmef_pkg::EV_RETURN_DONE)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_HOVER;
                    r.action = fmef_pkg::ACT_SET_HOVER;
                end
            fmef_pkg::MODE_LAND:
                if (ev == fmef_pkg::EV_LAND_DONE)
                begin
                    r.hit = 1'b1; r.next_mode = fmef_pkg::MODE_INIT;
                end
            default:
                r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // Advances the predicted state by one command and returns its result.
    function automatic flight_result_t next_supervisor_result(logic cmd,
                                                              fmef_pkg::code_t code,
                                                              logic rdy, logic tko);
        flight_result_t       r;
        fmef_pkg::table_res_t t;
        fmef_pkg::code_t      head;
        int                   newest;
        r.transitioned = 1'b0;
        r.action       = fmef_pkg::ACT_NONE;
        r.status       = fmef_pkg::ST_OK;
        if (cmd == fmef_pkg::CMD_ENQUEUE)
        begin
            newest = (fifo_wr == 0) ? QDEPTH - 1 : fifo_wr - 1;
            // The duplicate test wins over the full test.
            if (fifo_count != 0 && event_fifo[newest] == code)
                r.status = fmef_pkg::ST_DUPLICATE;
            else if (fifo_count >= QDEPTH)
                r.status = fmef_pkg::ST_FULL;
            else
            begin
                event_fifo[fifo_wr] = code;
                fifo_wr = (fifo_wr + 1) % QDEPTH;
                fifo_count++;
            end
        end
        else if (fifo_count == 0)
            r.status = fmef_pkg::ST_EMPTY;
        else
        begin
            head = event_fifo[fifo_rd];
            fifo_rd = (fifo_rd + 1) % QDEPTH;
            fifo_count--;
            if (head == fmef_pkg::EV_KILL)
            begin
                // Kill is taken from every mode, kill itself included.
                sup_mode = fmef_pkg::MODE_KILL;
                r.transitioned = 1'b1;
            end
            else
            begin
                t = mode_table(sup_mode, head, rdy, tko);
                if (t.hit)
                begin
                    sup_mode = t.next_mode;
                    r.transitioned = 1'b1;
                    r.action = t.action;
                end
            end
        end
        r.mode   = sup_mode;
        r.qcount = fmef_pkg::qcount_t'(fifo_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Transfers and checking
    // ------------------------------------------------------------------------

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Sends one command transfer. Valid is left high at the accepting edge so
    // that a back-to-back item needs no second assignment in that step.
    task automatic send_item(input logic cmd, input fmef_pkg::code_t code,
                             input logic rdy, input logic tko);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command       <= cmd;
        event_code    <= code;
        ctrl_ready    <= rdy;
        allow_takeoff <= tko;
        cmd_valid     <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        pending_results.insert(pending_results.size(),
                               next_supervisor_result(cmd, code, rdy, tko));
        items_sent++;
    endtask

    // Result side: draws a stall for every result, then takes it.
    initial
    begin
        int stall;
        res_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        flight_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_error($sformatf("result %0d arrived with nothing expected",
                                       results_seen));
            else
            begin
                want = pending_results.pop_front();
                if (mode !== want.mode)
                    report_error($sformatf("result %0d mode got %0d want %0d",
                                           results_seen, mode, want.mode));
                if (transitioned !== want.transitioned)
                    report_error($sformatf("result %0d transitioned got %0d want %0d",
                                           results_seen, transitioned, want.transitioned));
                if (action !== want.action)
                    report_error($sformatf("result %0d action got %0d want %0d",
                                           results_seen, action, want.action));
                if (status !== want.status)
                    report_error($sformatf("result %0d status got %0d want %0d",
                                           results_seen, status, want.status));
                if (queue_count !== want.qcount)
                    report_error($sformatf("result %0d queue_count got %0d want %0d",
                                           results_seen, queue_count, want.qcount));
                modes_seen[want.mode] = 1'b1;
                status_hits[want.status]++;
                if (want.action <= fmef_pkg::ACT_SET_HOVER)
                    action_hits[want.action]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Any code, half of the time from the table range; kill only if allowed.
    function automatic fmef_pkg::code_t pick_noise_code(logic allow_kill);
        fmef_pkg::code_t c;
        do
            c = ($urandom_range(0, 1) == 0) ? fmef_pkg::code_t'($urandom_range(0, 15))
                                             : fmef_pkg::code_t'($urandom_range(0, 31));
        while (!allow_kill && c == fmef_pkg::EV_KILL);
        return c;
    endfunction

    // A code that the table accepts in the given mode.
    function automatic fmef_pkg::code_t pick_legal_code(fmef_pkg::mode_t m);
        int r;
        r = $urandom_range(0, 9);
        case (m)
            fmef_pkg::MODE_OFF:     return fmef_pkg::EV_CTRL_READY;
            fmef_pkg::MODE_INIT:    return fmef_pkg::EV_TAKEOFF_REQ;
            fmef_pkg::MODE_TAKEOFF: return fmef_pkg::EV_TAKEOFF_DONE;
            fmef_pkg::MODE_HOVER:
                if (r < 7)
                    return fmef_pkg::code_t'($urandom_range(fmef_pkg::EV_POINT_REQ,
                                                            fmef_pkg::EV_WGS84_POINT_REQ));
                else if (r == 7) return fmef_pkg::EV_RETURN_REQ;
                else             return fmef_pkg::EV_LAND_REQ;
            fmef_pkg::MODE_MOVE:
                if (r < 3)
                    return fmef_pkg::code_t'($urandom_range(fmef_pkg::EV_POINT_REQ,
                                                            fmef_pkg::EV_WGS84_POINT_REQ));
                else if (r < 7)
                    return fmef_pkg::code_t'($urandom_range(fmef_pkg::EV_HOVER_REQ,
                                                            fmef_pkg::EV_WGS84_DONE));
                else if (r == 7) return fmef_pkg::EV_RETURN_REQ;
                else             return fmef_pkg::EV_LAND_REQ;
            fmef_pkg::MODE_RETURN:
                if (r < 4)       return fmef_pkg::EV_LAND_REQ;
                else if (r < 7)  return fmef_pkg::EV_HOVER_REQ;
                else             return fmef_pkg::EV_RETURN_DONE;
            fmef_pkg::MODE_LAND:    return fmef_pkg::EV_LAND_DONE;
            default:                return fmef_pkg::EV_KILL;
        endcase
    endfunction

    // Guard flag that is mostly set.
    function automatic logic mostly_set();
        return ($urandom_range(0, 99) < 85);
    endfunction

    // Queues one event and handles it at once.
    task automatic run_event(input fmef_pkg::code_t code, input logic rdy, input logic tko);
        send_item(fmef_pkg::CMD_ENQUEUE, code, rdy, tko);
        send_item(fmef_pkg::CMD_PROCESS, fmef_pkg::code_t'($urandom_range(0, 31)), rdy, tko);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Pop on an empty queue, a duplicate, and both guards held false.
    task automatic test_empty_and_guards();
        send_item(fmef_pkg::CMD_PROCESS, fmef_pkg::EV_CTRL_READY, 1'b1, 1'b1);
        send_item(fmef_pkg::CMD_ENQUEUE, fmef_pkg::EV_CTRL_READY, 1'b0, 1'b0);
        send_item(fmef_pkg::CMD_ENQUEUE, fmef_pkg::EV_CTRL_READY, 1'b1, 1'b1);
        send_item(fmef_pkg::CMD_PROCESS, fmef_pkg::EV_CTRL_READY, 1'b0, 1'b1);
        run_event(fmef_pkg::EV_CTRL_READY, 1'b1, 1'b0);
        run_event(fmef_pkg::EV_TAKEOFF_REQ, 1'b1, 1'b0);
        run_event(fmef_pkg::EV_TAKEOFF_REQ, 1'b0, 1'b1);
    endtask

    // One walk through every flying mode and back to init, then two codes
    // that init does not accept.
    task automatic test_mission_walk();
        run_event(fmef_pkg::EV_TAKEOFF_DONE, 1'b0, 1'b0);
        run_event(fmef_pkg::EV_POINT_REQ, 1'b0, 1'b0);
        run_event(fmef_pkg::EV_HOVER_REQ, 1'b1, 1'b1);
        run_event(fmef_pkg::EV_RETURN_REQ, 1'b0, 1'b1);
        run_event(fmef_pkg::EV_RETURN_DONE, 1'b1, 1'b0);
        run_event(fmef_pkg::EV_LAND_REQ, 1'b0, 1'b0);
        run_event(fmef_pkg::EV_LAND_DONE, 1'b1, 1'b1);
        run_event(fmef_pkg::EV_WGS84_DONE, 1'b1, 1'b1);
        run_event(fmef_pkg::code_t'(31), 1'b1, 1'b1);
    endtask

    // Mostly well-formed missions with random content, the rest noise. The
    // idle-free stretches come every fourth block.
    task automatic test_random_missions(input int n_items);
        int   done;
        logic rdy;
        logic tko;
        done = 0;
        while (done < n_items)
        begin
            quiet = ((done / 100) % 4 == 3);
            if ($urandom_range(0, 99) < 65)
            begin
                if (fifo_count == 0)
                begin
                    rdy = mostly_set();
                    tko = mostly_set();
                    run_event(pick_legal_code(sup_mode), rdy, tko);
                    done += 2;
                end
                else
                begin
                    send_item(fmef_pkg::CMD_PROCESS, pick_noise_code(1'b0),
                              mostly_set(), mostly_set());
                    done++;
                end
            end
            else
            begin
                send_item(logic'($urandom_range(0, 1)), pick_noise_code(1'b0),
                          logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
                done++;
            end
        end
        quiet = 1'b0;
    endtask

    // Fill the queue, overflow it, offer a duplicate while full, then drain
    // it past empty.
    task automatic test_queue_limits(input int rounds);
        fmef_pkg::code_t newest;
        fmef_pkg::code_t other;
        repeat (rounds)
        begin
            while (fifo_count < QDEPTH)
                send_item(fmef_pkg::CMD_ENQUEUE, pick_noise_code(1'b0),
                          logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
            newest = event_fifo[(fifo_wr + QDEPTH - 1) % QDEPTH];
            do
                other = pick_noise_code(1'b0);
            while (other == newest);
            send_item(fmef_pkg::CMD_ENQUEUE, other, 1'b1, 1'b1);
            send_item(fmef_pkg::CMD_ENQUEUE, newest, 1'b0, 1'b0);
            while (fifo_count > 0)
                send_item(fmef_pkg::CMD_PROCESS, pick_noise_code(1'b0),
                          mostly_set(), mostly_set());
            send_item(fmef_pkg::CMD_PROCESS, fmef_pkg::EV_KILL, 1'b1, 1'b1);
        end
    endtask

    // Kill is final for the run, so it comes last: kill from the mode that the
    // earlier tests left, kill again while killed, then noise with every code allowed.
    task automatic test_kill(input int n_noise);
        send_item(fmef_pkg::CMD_ENQUEUE, fmef_pkg::EV_KILL, 1'b0, 1'b0);
        send_item(fmef_pkg::CMD_ENQUEUE, fmef_pkg::EV_KILL, 1'b1, 1'b1);
        send_item(fmef_pkg::CMD_PROCESS, fmef_pkg::EV_CTRL_READY, 1'b1, 1'b1);
        send_item(fmef_pkg::CMD_PROCESS, fmef_pkg::EV_CTRL_READY, 1'b1, 1'b1);
        run_event(fmef_pkg::EV_KILL, 1'b0, 1'b1);
        run_event(fmef_pkg::EV_LAND_DONE, 1'b1, 1'b1);
        repeat (n_noise)
            send_item(logic'($urandom_range(0, 1)), pick_noise_code(1'b1),
                      logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------

    initial
    begin
        int wait_cycles;
        rst_n         <= 1'b0;
        cmd_valid     <= 1'b0;
        command       <= fmef_pkg::CMD_ENQUEUE;
        event_code    <= fmef_pkg::EV_CTRL_READY;
        ctrl_ready    <= 1'b0;
        allow_takeoff <= 1'b0;
        sup_mode   = fmef_pkg::MODE_OFF;
        fifo_rd    = 0;
        fifo_wr    = 0;
        fifo_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_guards();
        test_mission_walk();
        test_random_missions(1200);
        test_queue_limits(4);
        test_random_missions(200);
        test_kill(250);

        cmd_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        while (pending_results.size() != 0)
        begin
            report_error($sformatf("expected result never arrived (mode %0d, status %0d)",
                                   pending_results[0].mode, pending_results[0].status));
            void'(pending_results.pop_front());
        end

        $display("Sent %0d commands, checked %0d results; modes reached %b.",
                 items_sent, results_seen, modes_seen);
        $display("Status ok/dup/full/empty: %0d/%0d/%0d/%0d; actions home/hover: %0d/%0d.",
                 status_hits[fmef_pkg::ST_OK], status_hits[fmef_pkg::ST_DUPLICATE],
                 status_hits[fmef_pkg::ST_FULL], status_hits[fmef_pkg::ST_EMPTY],
                 action_hits[fmef_pkg::ACT_RECORD_HOME],
                 action_hits[fmef_pkg::ACT_SET_HOVER]);
        if (error_count == 0)
            $display("flight_mode_event_fsm_tb: clean");
        else
            $display("flight_mode_event_fsm_tb: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 2000 transfers.
    initial
    begin
        #(4_000_000);
        $display("Timeout: run did not complete.");
        $display("flight_mode_event_fsm_tb: errors");
        $finish;
    end

endmodule
